// File: sv/rbc_pkg.sv
package rbc_pkg;

	localparam int VAL_W             = 30;
	localparam int SB_W              = 4;
	localparam int TB_W              = 6;
	localparam int DIG_W             = 6;
	localparam int CHR_W             = 7;
	localparam int MAX_OUT_DIGITS    = 30;
	localparam int IN_DECIMAL_DIGITS = 9;
	localparam int DEC_RADIX         = 10;
	localparam int TB_MIN            = 2;
	localparam int TB_MAX            = 36;
	localparam int ASCII_ZERO        = 48;
	localparam int ASCII_A           = 65;

	localparam int DIV_STEP_BITS = 6;
	localparam int DIV_CYCLES    = (VAL_W + DIV_STEP_BITS - 1) / DIV_STEP_BITS;
	localparam int DIV_CNT_W     = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;
	localparam int DEC_CNT_W     = (IN_DECIMAL_DIGITS > 1) ? $clog2(IN_DECIMAL_DIGITS) : 1;
	localparam int IDX_W         = $clog2(MAX_OUT_DIGITS);
	localparam int CNT_W         = $clog2(MAX_OUT_DIGITS + 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DEC_DIV,
		ST_DEC_MAC,
		ST_CNV_DIV,
		ST_RD,
		ST_OUT
	} state_t;

	function automatic logic [CHR_W-1:0] digit_to_ascii(input logic [DIG_W-1:0] d);
		logic [CHR_W-1:0] dx;
		dx = CHR_W'(d);
		if (d < DIG_W'(DEC_RADIX))
			return dx + CHR_W'(ASCII_ZERO);
		else
			return dx - CHR_W'(DEC_RADIX) + CHR_W'(ASCII_A);
	endfunction

endpackage

// File: sv/rbc_num_if.sv
interface rbc_num_if;
	logic                         valid;
	logic                         ready;
	logic [rbc_pkg::VAL_W-1:0]    coded_value;
	logic [rbc_pkg::SB_W-1:0]     source_base;
	logic [rbc_pkg::TB_W-1:0]     target_base;

	modport source (output valid, coded_value, source_base, target_base, input ready);
	modport sink (input valid, coded_value, source_base, target_base, output ready);
endinterface

// File: sv/rbc_dig_if.sv
interface rbc_dig_if;
	logic                         valid;
	logic                         ready;
	logic [rbc_pkg::DIG_W-1:0]    digit_value;
	logic [rbc_pkg::CHR_W-1:0]    digit_char;
	logic                         last_digit;

	modport source (output valid, digit_value, digit_char, last_digit, input ready);
	modport sink (input valid, digit_value, digit_char, last_digit, output ready);
endinterface

// File: sv/radix_base_converter_core.sv
// Radix converter: reads the decimal digits of coded_value as digits in
// source_base, forms their positional value and sends it out in target_base,
// most significant digit first, one word per digit on the digits channel.
// Each digit word carries the digit value, its ASCII character and a mark
// on the final digit of the run; a zero value gives the single digit 0.
// number: one word per conversion, taken only while the core is idle.
// Steps; the divide passes all run on one shared divider that retires 6 dividend bits a cycle:
//   accept: the number word is registered
//   decimal digits: a divide pass then a multiply-add each, at most 9,
//     stopping early once the remaining decimal digits are all zero
//   target digits: a divide pass each, at most 30
//   output: a store read then the output register, per digit
// The next number word is taken in the cycle after the last digit leaves.
// A stalled receiver holds the current digit word steady in the output
// register and stalls the core.
// Reset returns the core to idle with no digit pending; the digit store
// is not cleared.
module radix_base_converter_core (
	input  logic       clk,
	input  logic       arst_n,
	rbc_num_if.sink    number,
	rbc_dig_if.source  digits
);

	rbc_pkg::state_t                state_q, state_nxt;
	logic [rbc_pkg::DIV_CNT_W-1:0]  div_cnt_q;
	logic [rbc_pkg::DEC_CNT_W-1:0]  dec_cnt_q;
	logic [rbc_pkg::CNT_W-1:0]      dcnt_q;
	logic [rbc_pkg::IDX_W-1:0]      rd_ptr_q;

	logic [rbc_pkg::VAL_W-1:0]      num_q;
	logic [rbc_pkg::DIG_W-1:0]      rem_q;
	logic [rbc_pkg::VAL_W-1:0]      acc_q;
	logic [rbc_pkg::VAL_W-1:0]      pow_q;
	logic [rbc_pkg::SB_W-1:0]       sbase_q;
	logic [rbc_pkg::TB_W-1:0]       tbase_q;
	logic [rbc_pkg::DIG_W-1:0]      rd_data_q;
	logic [rbc_pkg::DIG_W-1:0]      store_q [rbc_pkg::MAX_OUT_DIGITS];

	logic                           accept;
	logic                           div_last;
	logic [rbc_pkg::TB_W-1:0]       den;
	logic [rbc_pkg::VAL_W-1:0]      div_quo;
	logic [rbc_pkg::DIG_W-1:0]      div_rem;
	logic [rbc_pkg::DIG_W-1:0]      r_w;
	logic [rbc_pkg::DIG_W:0]        t_w;
	logic [rbc_pkg::VAL_W-1:0]      n_w;
	logic [rbc_pkg::VAL_W-1:0]      acc_nxt;
	logic [rbc_pkg::VAL_W-1:0]      pow_nxt;
	logic [rbc_pkg::TB_W-1:0]       tb_clamp;
	logic                           dec_done;
	logic                           cnv_done;
	logic                           st_wr;
	logic                           st_rd;

	assign accept   = number.valid && number.ready;
	assign div_last = div_cnt_q == rbc_pkg::DIV_CNT_W'(rbc_pkg::DIV_CYCLES - 1);
	assign den      = (state_q == rbc_pkg::ST_DEC_DIV) ?
	                  rbc_pkg::TB_W'(rbc_pkg::DEC_RADIX) : tbase_q;

	// shared small-divisor long divider, several dividend bits per cycle
	always_comb begin
		r_w = rem_q;
		n_w = num_q;
		t_w = '0;
		for (int i = 0; i < rbc_pkg::DIV_STEP_BITS; i++) begin
			t_w = {r_w, n_w[rbc_pkg::VAL_W-1]};
			n_w = {n_w[rbc_pkg::VAL_W-2:0], 1'b0};
			if (t_w >= {1'b0, den}) begin
				t_w    = t_w - {1'b0, den};
				n_w[0] = 1'b1;
			end
			r_w = t_w[rbc_pkg::DIG_W-1:0];
		end
		div_quo = n_w;
		div_rem = r_w;
	end

	assign acc_nxt = acc_q + rbc_pkg::VAL_W'(rem_q * pow_q);
	assign pow_nxt = rbc_pkg::VAL_W'(pow_q * sbase_q);

	always_comb begin
		if (number.target_base < rbc_pkg::TB_W'(rbc_pkg::TB_MIN))
			tb_clamp = rbc_pkg::TB_W'(rbc_pkg::TB_MIN);
		else if (number.target_base > rbc_pkg::TB_W'(rbc_pkg::TB_MAX))
			tb_clamp = rbc_pkg::TB_W'(rbc_pkg::TB_MAX);
		else
			tb_clamp = number.target_base;
	end

	assign dec_done = (num_q == '0) ||
	                  (dec_cnt_q == rbc_pkg::DEC_CNT_W'(rbc_pkg::IN_DECIMAL_DIGITS - 1));
	assign cnv_done = (div_quo == '0) ||
	                  (dcnt_q == rbc_pkg::CNT_W'(rbc_pkg::MAX_OUT_DIGITS - 1));

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			rbc_pkg::ST_IDLE: begin
				if (number.valid)
					state_nxt = rbc_pkg::ST_DEC_DIV;
			end
			rbc_pkg::ST_DEC_DIV: begin
				if (div_last)
					state_nxt = rbc_pkg::ST_DEC_MAC;
			end
			rbc_pkg::ST_DEC_MAC: begin
				state_nxt = dec_done ? rbc_pkg::ST_CNV_DIV : rbc_pkg::ST_DEC_DIV;
			end
			rbc_pkg::ST_CNV_DIV: begin
				if (div_last && cnv_done)
					state_nxt = rbc_pkg::ST_RD;
			end
			rbc_pkg::ST_RD: begin
				state_nxt = rbc_pkg::ST_OUT;
			end
			rbc_pkg::ST_OUT: begin
				if (digits.ready)
					state_nxt = (rd_ptr_q == '0) ? rbc_pkg::ST_IDLE : rbc_pkg::ST_RD;
			end
			default: begin
				state_nxt = rbc_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		number.ready       = state_q == rbc_pkg::ST_IDLE;
		digits.valid       = state_q == rbc_pkg::ST_OUT;
		digits.digit_value = rd_data_q;
		digits.digit_char  = rbc_pkg::digit_to_ascii(rd_data_q);
		digits.last_digit  = rd_ptr_q == '0;
		st_wr              = (state_q == rbc_pkg::ST_CNV_DIV) && div_last;
		st_rd              = state_q == rbc_pkg::ST_RD;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= rbc_pkg::ST_IDLE;
			div_cnt_q <= '0;
			dec_cnt_q <= '0;
			dcnt_q    <= '0;
			rd_ptr_q  <= '0;
		end else begin
			state_q <= state_nxt;
			if (accept) begin
				div_cnt_q <= '0;
				dec_cnt_q <= '0;
				dcnt_q    <= '0;
			end
			if (state_q == rbc_pkg::ST_DEC_DIV || state_q == rbc_pkg::ST_CNV_DIV)
				div_cnt_q <= div_last ? '0 : div_cnt_q + 1'b1;
			if (state_q == rbc_pkg::ST_DEC_MAC)
				dec_cnt_q <= dec_cnt_q + 1'b1;
			if (st_wr) begin
				dcnt_q   <= dcnt_q + 1'b1;
				rd_ptr_q <= dcnt_q[rbc_pkg::IDX_W-1:0];
			end
			if (state_q == rbc_pkg::ST_OUT && digits.ready && rd_ptr_q != '0)
				rd_ptr_q <= rd_ptr_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			rbc_pkg::ST_IDLE: begin
				if (accept) begin
					num_q   <= number.coded_value;
					rem_q   <= '0;
					acc_q   <= '0;
					pow_q   <= rbc_pkg::VAL_W'(1);
					sbase_q <= number.source_base;
					tbase_q <= tb_clamp;
				end
			end
			rbc_pkg::ST_DEC_DIV: begin
				num_q <= div_quo;
				rem_q <= div_rem;
			end
			rbc_pkg::ST_DEC_MAC: begin
				acc_q <= acc_nxt;
				pow_q <= pow_nxt;
				rem_q <= '0;
				if (dec_done)
					num_q <= acc_nxt;
			end
			rbc_pkg::ST_CNV_DIV: begin
				num_q <= div_quo;
				rem_q <= div_last ? '0 : div_rem;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (st_wr)
			store_q[dcnt_q[rbc_pkg::IDX_W-1:0]] <= div_rem;
		if (st_rd)
			rd_data_q <= store_q[rd_ptr_q];
	end

	a_busy_no_take: assert property (@(posedge clk) disable iff (!arst_n)
		digits.valid |-> !number.ready)
		else $error("number taken while digits pending");

	a_take_then_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(number.valid && number.ready) |=> !number.ready && !digits.valid)
		else $error("core not busy after taking a number");

	a_last_then_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(digits.valid && digits.ready && digits.last_digit) |=> number.ready)
		else $error("core not idle after last digit");

	a_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		digits.valid |-> digits.digit_value < tbase_q)
		else $error("digit not below target base");

endmodule
